// File: src/sdrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stream clock drift tracker.
// No dependencies; imported by the top level, the divider and both checkers.
package sdrt_pkg;

   localparam int TIME_WIDTH  = 64;
   localparam int RATIO_WIDTH = 40;
   localparam int OP_WIDTH    = 3;

   localparam logic [OP_WIDTH-1:0] OP_START      = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_STOP       = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_ADJUST     = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_READ_TIME  = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_READ_SCALE = 3'd4;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] slave;
      logic [TIME_WIDTH-1:0] master;
   } hist_entry_type;

endpackage

// File: src/stream_clock_drift_tracker.sv
`timescale 1ns / 1ps
// Stream clock with drift tracking: top level sequencer, references and history.
// Depends on sdrt_pkg, sdrt_ram and sdrt_divider.
//
// Usage:
//   One command transfer on req_* (start, stop, adjust, read time, read scale)
//   yields exactly one result transfer on rsp_*, with stream time, run flag and
//   the master-to-local rate ratio taken after the command has acted.
//   The block works on one command at a time; req_ready is low while it does.
//   After accept the command is applied, the history is walked back from the
//   newest entry (at most HISTORY_DEPTH-1 entries walked) and, when the history
//   gives a ratio, the serial divider runs, one quotient bit per cycle; the
//   divider sets the worst case. A new command is accepted only once the last
//   one has been written to the output register.
//   The result sits in an output register, so the next command is accepted
//   while an unclaimed result waits; a finished command holds until rsp_ready
//   frees that register.
//   Reset (synchronous, active high) clears the references, the run flag, the
//   write slot and the history valid bits, so the history reads as all zero.
module stream_clock_drift_tracker #(
   parameter int HISTORY_DEPTH       = 10,
   parameter int RATIO_FRACTION_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic        [sdrt_pkg::OP_WIDTH-1:0]    req_operation,
   input  logic signed [sdrt_pkg::TIME_WIDTH-1:0]  req_system_time,
   input  logic signed [sdrt_pkg::TIME_WIDTH-1:0]  req_start_time,
   input  logic signed [sdrt_pkg::TIME_WIDTH-1:0]  req_slave_time,
   input  logic signed [sdrt_pkg::TIME_WIDTH-1:0]  req_master_time,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [sdrt_pkg::TIME_WIDTH-1:0]  rsp_stream_time,
   output logic                                    rsp_running,
   output logic signed [sdrt_pkg::RATIO_WIDTH-1:0] rsp_scale_ratio,
   output logic                                    rsp_scale_from_history
);
   import sdrt_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam logic [RATIO_WIDTH-1:0] RATIO_ONE = RATIO_WIDTH'(1) << RATIO_FRACTION_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_APPLY, ST_DELTA, ST_NEW, ST_ISSUE, ST_CHECK,
      ST_DIFF, ST_MDIFF, ST_START, ST_WAIT, ST_FINISH
   } state_type;

   function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] s);
      return (s == '0) ? AW'(HISTORY_DEPTH - 1) : s - 1'b1;
   endfunction

   state_type              state_ff, state_in;
   logic [OP_WIDTH-1:0]    op_ff, op_in;
   logic [TIME_WIDTH-1:0]  sys_ff, sys_in;
   logic [TIME_WIDTH-1:0]  start_ff, start_in;
   logic [TIME_WIDTH-1:0]  slave_ff, slave_in;
   logic [TIME_WIDTH-1:0]  master_ff, master_in;
   logic [TIME_WIDTH-1:0]  local_ref_ff, local_ref_in;
   logic [TIME_WIDTH-1:0]  ext_ref_ff, ext_ref_in;
   logic                   run_ff, run_in;
   logic [AW-1:0]          slot_ff, slot_in;
   logic [HISTORY_DEPTH-1:0] vld_ff, vld_in;
   logic                   rd_vld_ff;
   logic [AW-1:0]          cur_ff, cur_in;
   logic [AW-1:0]          steps_ff, steps_in;
   logic [TIME_WIDTH-1:0]  s_new_ff, s_new_in;
   logic [TIME_WIDTH-1:0]  m_new_ff, m_new_in;
   logic [TIME_WIDTH-1:0]  s_old_ff, s_old_in;
   logic [TIME_WIDTH-1:0]  m_old_ff, m_old_in;
   logic [TIME_WIDTH-1:0]  delta_ff, delta_in;
   logic [TIME_WIDTH-1:0]  sdiff_ff, sdiff_in;
   logic [TIME_WIDTH:0]    md_ff, md_in;
   logic                   from_hist_ff, from_hist_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TIME_WIDTH-1:0]  rsp_stream_ff, rsp_stream_in;
   logic                   rsp_running_ff, rsp_running_in;
   logic [RATIO_WIDTH-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic                   rsp_hist_ff, rsp_hist_in;

   logic                   wr_en;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          prev_cur;
   hist_entry_type         wr_entry, rd_raw, entry;
   logic [TIME_WIDTH:0]    sd;
   logic                   div_start, div_done;
   logic [TIME_WIDTH-1:0]  div_dividend;
   logic [RATIO_WIDTH-1:0] div_ratio;

   assign prev_cur = prev_slot(cur_ff);
   assign rd_addr  = (state_ff == ST_DELTA) ? prev_slot(slot_ff) : prev_cur;
   assign entry    = rd_vld_ff ? rd_raw : '0;
   assign wr_entry = '{slave: slave_ff, master: master_ff};
   assign sd       = {s_new_ff[TIME_WIDTH-1], s_new_ff} - {s_old_ff[TIME_WIDTH-1], s_old_ff};
   assign div_dividend = md_ff[TIME_WIDTH] ? (~md_ff[TIME_WIDTH-1:0] + 1'b1)
                                           : md_ff[TIME_WIDTH-1:0];

   sdrt_ram #(
      .WIDTH($bits(hist_entry_type)),
      .DEPTH(HISTORY_DEPTH)
   ) u_hist (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot_ff),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   sdrt_divider #(
      .RATIO_FRACTION_BITS(RATIO_FRACTION_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (sdiff_ff),
      .negative(md_ff[TIME_WIDTH]),
      .done    (div_done),
      .ratio   (div_ratio)
   );

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      sys_in         = sys_ff;
      start_in       = start_ff;
      slave_in       = slave_ff;
      master_in      = master_ff;
      local_ref_in   = local_ref_ff;
      ext_ref_in     = ext_ref_ff;
      run_in         = run_ff;
      slot_in        = slot_ff;
      vld_in         = vld_ff;
      cur_in         = cur_ff;
      steps_in       = steps_ff;
      s_new_in       = s_new_ff;
      m_new_in       = m_new_ff;
      s_old_in       = s_old_ff;
      m_old_in       = m_old_ff;
      delta_in       = delta_ff;
      sdiff_in       = sdiff_ff;
      md_in          = md_ff;
      from_hist_in   = from_hist_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_stream_in  = rsp_stream_ff;
      rsp_running_in = rsp_running_ff;
      rsp_ratio_in   = rsp_ratio_ff;
      rsp_hist_in    = rsp_hist_ff;
      wr_en          = 1'b0;
      div_start      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               sys_in    = req_system_time;
               start_in  = req_start_time;
               slave_in  = req_slave_time;
               master_in = req_master_time;
               state_in  = ST_APPLY;
            end
         end
         ST_APPLY: begin
            case (op_ff)
               OP_START: begin
                  local_ref_in = sys_ff;
                  ext_ref_in   = start_ff;
                  run_in       = 1'b1;
               end
               OP_STOP: begin
                  run_in = 1'b0;
               end
               OP_ADJUST: begin
                  local_ref_in    = slave_ff;
                  ext_ref_in      = master_ff;
                  wr_en           = 1'b1;
                  vld_in[slot_ff] = 1'b1;
                  slot_in = (slot_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               end
               default: begin
               end
            endcase
            state_in = ST_DELTA;
         end
         ST_DELTA: begin
            delta_in = sys_ff - local_ref_ff;
            cur_in   = prev_slot(slot_ff);
            steps_in = '0;
            state_in = ST_NEW;
         end
         ST_NEW: begin
            s_new_in = entry.slave;
            m_new_in = entry.master;
            s_old_in = entry.slave;
            m_old_in = entry.master;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!entry.slave[TIME_WIDTH-1] && |entry.slave) begin
               cur_in   = prev_cur;
               steps_in = steps_ff + 1'b1;
               s_old_in = entry.slave;
               m_old_in = entry.master;
               state_in = (steps_in == AW'(HISTORY_DEPTH - 1)) ? ST_DIFF : ST_ISSUE;
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            sdiff_in = sd[TIME_WIDTH-1:0];
            if (steps_ff == '0 || sd[TIME_WIDTH] || !(|sd[TIME_WIDTH-1:0])) begin
               from_hist_in = 1'b0;
               state_in     = ST_FINISH;
            end else begin
               from_hist_in = 1'b1;
               state_in     = ST_MDIFF;
            end
         end
         ST_MDIFF: begin
            md_in = {m_new_ff[TIME_WIDTH-1], m_new_ff} - {m_old_ff[TIME_WIDTH-1], m_old_ff};
            state_in = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_stream_in  = ext_ref_ff + delta_ff;
               rsp_running_in = run_ff;
               rsp_ratio_in   = from_hist_ff ? div_ratio : RATIO_ONE;
               rsp_hist_in    = from_hist_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         local_ref_ff <= '0;
         ext_ref_ff   <= '0;
         run_ff       <= 1'b0;
         slot_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         local_ref_ff <= local_ref_in;
         ext_ref_ff   <= ext_ref_in;
         run_ff       <= run_in;
         slot_ff      <= slot_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_vld_ff      <= vld_ff[rd_addr];
      op_ff          <= op_in;
      sys_ff         <= sys_in;
      start_ff       <= start_in;
      slave_ff       <= slave_in;
      master_ff      <= master_in;
      cur_ff         <= cur_in;
      steps_ff       <= steps_in;
      s_new_ff       <= s_new_in;
      m_new_ff       <= m_new_in;
      s_old_ff       <= s_old_in;
      m_old_ff       <= m_old_in;
      delta_ff       <= delta_in;
      sdiff_ff       <= sdiff_in;
      md_ff          <= md_in;
      from_hist_ff   <= from_hist_in;
      rsp_stream_ff  <= rsp_stream_in;
      rsp_running_ff <= rsp_running_in;
      rsp_ratio_ff   <= rsp_ratio_in;
      rsp_hist_ff    <= rsp_hist_in;
   end

   assign req_ready              = (state_ff == ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_stream_time        = rsp_stream_ff;
   assign rsp_running            = rsp_running_ff;
   assign rsp_scale_ratio        = rsp_ratio_ff;
   assign rsp_scale_from_history = rsp_hist_ff;

endmodule

// File: src/sdrt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdrt_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sdrt_divider.sv
`timescale 1ns / 1ps
// Serial restoring divider: (dividend * 2^F) / divisor, one quotient bit per cycle,
// with signed saturation of the ratio. Depends on sdrt_pkg.
module sdrt_divider #(
   parameter int RATIO_FRACTION_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [sdrt_pkg::TIME_WIDTH-1:0]    dividend,
   input  logic [sdrt_pkg::TIME_WIDTH-1:0]    divisor,
   input  logic                               negative,
   output logic                               done,
   output logic [sdrt_pkg::RATIO_WIDTH-1:0]   ratio
);
   import sdrt_pkg::*;

   localparam int STEPS = TIME_WIDTH + RATIO_FRACTION_BITS;
   localparam int CW    = $clog2(STEPS);
   localparam logic [RATIO_WIDTH-1:0] POS_MAX = {1'b0, {(RATIO_WIDTH-1){1'b1}}};
   localparam logic [RATIO_WIDTH-1:0] NEG_MAG = {1'b1, {(RATIO_WIDTH-1){1'b0}}};

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [TIME_WIDTH-1:0]  rem_ff, rem_in;
   logic [TIME_WIDTH-1:0]  dvd_ff, dvd_in;
   logic [TIME_WIDTH-1:0]  dvs_ff, dvs_in;
   logic [RATIO_WIDTH-1:0] q_ff, q_in;
   logic                   over_ff, over_in;
   logic                   neg_ff, neg_in;
   logic [TIME_WIDTH-1:0]  rem_sh;
   logic                   ge;
   logic [RATIO_WIDTH-1:0] mag;

   always_comb begin
      rem_sh  = {rem_ff[TIME_WIDTH-2:0], dvd_ff[TIME_WIDTH-1]};
      ge      = rem_sh >= dvs_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      over_in = over_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(STEPS - 1);
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         q_in    = '0;
         over_in = 1'b0;
         neg_in  = negative;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - dvs_ff : rem_sh;
         dvd_in = {dvd_ff[TIME_WIDTH-2:0], 1'b0};
         if (!over_ff) begin
            q_in    = {q_ff[RATIO_WIDTH-2:0], ge};
            over_in = q_ff[RATIO_WIDTH-1];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
      over_ff <= over_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      if (neg_ff) begin
         mag   = (over_ff || (q_ff[RATIO_WIDTH-1] && |q_ff[RATIO_WIDTH-2:0])) ? NEG_MAG : q_ff;
         ratio = ~mag + 1'b1;
      end else begin
         mag   = q_ff;
         ratio = (over_ff || q_ff[RATIO_WIDTH-1]) ? POS_MAX : q_ff;
      end
   end

   assign done = done_ff;

endmodule

// File: src/sdrt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the stream clock drift tracker, bound to the top level.
// Depends on sdrt_pkg and stream_clock_drift_tracker.
module sdrt_checker #(
   parameter int RATIO_FRACTION_BITS = 24
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [sdrt_pkg::TIME_WIDTH-1:0]  rsp_stream_time,
   input logic signed [sdrt_pkg::RATIO_WIDTH-1:0] rsp_scale_ratio,
   input logic                                    rsp_scale_from_history
);
   import sdrt_pkg::*;

   localparam logic [RATIO_WIDTH-1:0] RATIO_ONE = RATIO_WIDTH'(1) << RATIO_FRACTION_BITS;

   a_reset_empty: assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a command transfer");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a command in progress");

   a_default_ratio: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_scale_from_history) |-> (rsp_scale_ratio == RATIO_ONE))
      else $error("default ratio is not 1.0");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_stream_time)))
      else $error("stalled result changed");

endmodule

bind stream_clock_drift_tracker sdrt_checker #(
   .RATIO_FRACTION_BITS(RATIO_FRACTION_BITS)
) u_sdrt_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_stream_time       (rsp_stream_time),
   .rsp_scale_ratio       (rsp_scale_ratio),
   .rsp_scale_from_history(rsp_scale_from_history)
);

// File: tb/sv/stream_clock_drift_checker.sv
`timescale 1ns / 1ps
// Checker for the stream clock drift tracker: tracks the clock state on every command
// transfer, predicts the result and compares it field by field with each result transfer.
// Depends on sdrt_pkg for widths and command codes.
module stream_clock_drift_checker #(
   parameter int HIST_DEPTH = 10,
   parameter int FRAC_BITS  = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic [sdrt_pkg::OP_WIDTH-1:0]           req_operation,
   input  logic signed [sdrt_pkg::TIME_WIDTH-1:0]  req_system_time,
   input  logic signed [sdrt_pkg::TIME_WIDTH-1:0]  req_start_time,
   input  logic signed [sdrt_pkg::TIME_WIDTH-1:0]  req_slave_time,
   input  logic signed [sdrt_pkg::TIME_WIDTH-1:0]  req_master_time,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [sdrt_pkg::TIME_WIDTH-1:0]  rsp_stream_time,
   input  logic                                    rsp_running,
   input  logic signed [sdrt_pkg::RATIO_WIDTH-1:0] rsp_scale_ratio,
   input  logic                                    rsp_scale_from_history,
   output int                                      error_count,
   output int                                      pending_count,
   output int                                      command_count,
   output int                                      history_ratio_count
);
   import sdrt_pkg::*;

   localparam int QUOT_WIDTH = TIME_WIDTH + FRAC_BITS;
   localparam logic [QUOT_WIDTH-1:0] POS_LIMIT = (QUOT_WIDTH'(1) << (RATIO_WIDTH - 1)) - 1;
   localparam logic [QUOT_WIDTH-1:0] NEG_LIMIT = QUOT_WIDTH'(1) << (RATIO_WIDTH - 1);
   localparam logic [RATIO_WIDTH-1:0] UNITY_RATIO = RATIO_WIDTH'(1) << FRAC_BITS;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]  stream_time;
      logic                   running;
      logic [RATIO_WIDTH-1:0] ratio;
      logic                   from_history;
   } clock_reading_type;

   logic signed [TIME_WIDTH-1:0] local_ref;
   logic signed [TIME_WIDTH-1:0] external_ref;
   logic                         run_state;
   logic signed [TIME_WIDTH-1:0] slave_log [HIST_DEPTH];
   logic signed [TIME_WIDTH-1:0] master_log [HIST_DEPTH];
   int unsigned                  write_slot;

   clock_reading_type expected_readings [$];
   int errors = 0;
   int commands = 0;
   int history_ratios = 0;

   task automatic report_mismatch(input string what, input logic [TIME_WIDTH-1:0] got,
                                  input logic [TIME_WIDTH-1:0] want);
      errors++;
      $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   function automatic void derive_rate(output logic [RATIO_WIDTH-1:0] ratio,
                                       output logic from_history);
      int unsigned newest, oldest, steps;
      logic signed [TIME_WIDTH-1:0] s_new, s_old, m_new, m_old;
      logic [TIME_WIDTH-1:0] slave_span, master_mag;
      logic [QUOT_WIDTH-1:0] quotient;
      ratio = UNITY_RATIO;
      from_history = 1'b0;
      newest = (write_slot + HIST_DEPTH - 1) % HIST_DEPTH;
      oldest = newest;
      steps = 0;
      // walk back while the older slave entry is positive
      while (steps < HIST_DEPTH - 1 &&
             slave_log[(oldest + HIST_DEPTH - 1) % HIST_DEPTH] > 0) begin
         oldest = (oldest + HIST_DEPTH - 1) % HIST_DEPTH;
         steps++;
      end
      s_new = slave_log[newest];
      s_old = slave_log[oldest];
      if (steps == 0 || s_new <= s_old)
         return;
      slave_span = s_new - s_old;
      m_new = master_log[newest];
      m_old = master_log[oldest];
      master_mag = (m_new >= m_old) ? m_new - m_old : m_old - m_new;
      quotient = ({{FRAC_BITS{1'b0}}, master_mag} << FRAC_BITS) /
                 {{FRAC_BITS{1'b0}}, slave_span};
      if (m_new >= m_old) begin
         ratio = (quotient > POS_LIMIT) ? POS_LIMIT[RATIO_WIDTH-1:0]
                                        : quotient[RATIO_WIDTH-1:0];
      end else begin
         if (quotient > NEG_LIMIT)
            quotient = NEG_LIMIT;
         ratio = -quotient[RATIO_WIDTH-1:0];
      end
      from_history = 1'b1;
   endfunction

   function automatic clock_reading_type predict_reading(
      input logic [OP_WIDTH-1:0] op, input logic signed [TIME_WIDTH-1:0] sys,
      input logic signed [TIME_WIDTH-1:0] start, input logic signed [TIME_WIDTH-1:0] slave,
      input logic signed [TIME_WIDTH-1:0] master);
      clock_reading_type r;
      logic [RATIO_WIDTH-1:0] ratio;
      logic from_history;
      case (op)
         OP_START: begin
            local_ref = sys;
            external_ref = start;
            run_state = 1'b1;
         end
         OP_STOP: run_state = 1'b0;
         OP_ADJUST: begin
            local_ref = slave;
            external_ref = master;
            slave_log[write_slot] = slave;
            master_log[write_slot] = master;
            write_slot = (write_slot + 1) % HIST_DEPTH;
         end
         default: ;
      endcase
      derive_rate(ratio, from_history);
      r.stream_time = external_ref + (sys - local_ref);
      r.running = run_state;
      r.ratio = ratio;
      r.from_history = from_history;
      return r;
   endfunction

   always @(posedge clock) begin
      clock_reading_type want;
      if (reset) begin
         local_ref = '0;
         external_ref = '0;
         run_state = 1'b0;
         write_slot = 0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            slave_log[i] = '0;
            master_log[i] = '0;
         end
         expected_readings.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("result transfer with no command", rsp_stream_time, '0);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_stream_time !== want.stream_time)
                  report_mismatch("stream_time", rsp_stream_time, want.stream_time);
               if (rsp_running !== want.running)
                  report_mismatch("running", TIME_WIDTH'(rsp_running),
                                  TIME_WIDTH'(want.running));
               if (rsp_scale_ratio !== want.ratio)
                  report_mismatch("scale_ratio", TIME_WIDTH'(rsp_scale_ratio),
                                  TIME_WIDTH'(want.ratio));
               if (rsp_scale_from_history !== want.from_history)
                  report_mismatch("scale_from_history", TIME_WIDTH'(rsp_scale_from_history),
                                  TIME_WIDTH'(want.from_history));
               if (want.from_history)
                  history_ratios++;
            end
         end
         if (req_valid && req_ready) begin
            expected_readings.push_back(predict_reading(req_operation, req_system_time,
               req_start_time, req_slave_time, req_master_time));
            commands++;
         end
      end
      error_count <= errors;
      pending_count <= expected_readings.size();
      command_count <= commands;
      history_ratio_count <= history_ratios;
   end

endmodule

// File: tb/sv/stream_clock_drift_tracker_tb.sv
`timescale 1ns / 1ps
// Testbench top for the stream clock drift tracker: clock, reset, command stimulus and
// result back-pressure. Depends on sdrt_pkg, the block and stream_clock_drift_checker.
module stream_clock_drift_tracker_tb;
   import sdrt_pkg::*;

   localparam int HIST_DEPTH = 10;
   localparam int FRAC_BITS = 24;
   localparam int RANDOM_PER_PHASE = 225;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [OP_WIDTH-1:0] OP_SPARE_LOW = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_SPARE_HIGH = 3'd7;
   localparam logic signed [TIME_WIDTH-1:0] TIME_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
   localparam logic signed [TIME_WIDTH-1:0] TIME_MIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_WIDTH-1:0] req_operation = OP_READ_TIME;
   logic signed [TIME_WIDTH-1:0] req_system_time = '0;
   logic signed [TIME_WIDTH-1:0] req_start_time = '0;
   logic signed [TIME_WIDTH-1:0] req_slave_time = '0;
   logic signed [TIME_WIDTH-1:0] req_master_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b1;
   logic signed [TIME_WIDTH-1:0] rsp_stream_time;
   logic rsp_running;
   logic signed [RATIO_WIDTH-1:0] rsp_scale_ratio;
   logic rsp_scale_from_history;

   int error_count, pending_count, command_count, history_ratio_count;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycle_count = 0;
   logic signed [TIME_WIDTH-1:0] slave_line;
   logic signed [TIME_WIDTH-1:0] master_line;

   stream_clock_drift_tracker #(
      .HISTORY_DEPTH(HIST_DEPTH),
      .RATIO_FRACTION_BITS(FRAC_BITS)
   ) uut (.*);

   stream_clock_drift_checker #(
      .HIST_DEPTH(HIST_DEPTH),
      .FRAC_BITS(FRAC_BITS)
   ) drift_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [TIME_WIDTH-1:0] rand_time();
      return {$urandom, $urandom};
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_command(input logic [OP_WIDTH-1:0] op,
                               input logic [TIME_WIDTH-1:0] sys, start, slave, master);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_system_time <= sys;
      req_start_time <= start;
      req_slave_time <= slave;
      req_master_time <= master;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_command();
      logic signed [TIME_WIDTH-1:0] slave_step, master_step, sys_now;
      int unsigned pick;
      pick = $urandom_range(99);
      slave_step = ($urandom_range(9) == 0) ? TIME_WIDTH'({$urandom_range(1, 65535), 16'h0})
                                            : TIME_WIDTH'($urandom_range(1, 1 << 20));
      case ($urandom_range(9))
         0: master_step = rand_time();
         1: master_step = -slave_step * TIME_WIDTH'($urandom_range(1, 3));
         2: master_step = 0;
         default: master_step = slave_step + TIME_WIDTH'($urandom_range(0, 2000)) - 1000;
      endcase
      sys_now = slave_line + TIME_WIDTH'($urandom_range(0, 1 << 16));
      if (pick < 35) begin
         slave_line = slave_line + slave_step;
         master_line = master_line + master_step;
         send_command(OP_ADJUST, sys_now, rand_time(), slave_line, master_line);
      end else if (pick < 55) begin
         send_command(OP_READ_SCALE, sys_now, rand_time(), rand_time(), rand_time());
      end else if (pick < 70) begin
         send_command(OP_READ_TIME, rand_time(), rand_time(), rand_time(), rand_time());
      end else if (pick < 77) begin
         send_command(OP_START, sys_now, rand_time(), rand_time(), rand_time());
      end else if (pick < 83) begin
         send_command(OP_STOP, sys_now, rand_time(), rand_time(), rand_time());
      end else if (pick < 90) begin
         // break the history: zero, negative, backward or wild slave sample
         case ($urandom_range(3))
            0: slave_line = 0;
            1: slave_line = -$signed(rand_time() >> 1);
            2: slave_line = TIME_WIDTH'($urandom_range(1, 1000));
            default: slave_line = rand_time();
         endcase
         master_line = rand_time();
         send_command(OP_ADJUST, sys_now, rand_time(), slave_line, master_line);
         if (slave_line <= 0)
            slave_line = TIME_WIDTH'($urandom_range(1, 1000));
      end else begin
         send_command(OP_WIDTH'($urandom_range(7)), rand_time(), rand_time(), rand_time(),
                      rand_time());
      end
   endtask

   initial begin
      slave_line = {$urandom_range(1, 255), 32'h0};
      master_line = rand_time();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_command(OP_READ_SCALE, '0, '0, '0, '0);
      send_command(OP_READ_TIME, TIME_MAX, '0, '0, '0);
      send_command(OP_START, TIME_MIN, TIME_MAX, '0, '0);
      send_command(OP_READ_TIME, TIME_MAX, TIME_MIN, '0, '0);
      send_command(OP_STOP, TIME_MIN, '0, '0, '0);
      for (int op = OP_SPARE_LOW; op <= OP_SPARE_HIGH; op++)
         send_command(OP_WIDTH'(op), rand_time(), rand_time(), rand_time(), rand_time());
      send_command(OP_ADJUST, 150, '0, 100, 1000);
      send_command(OP_ADJUST, 250, '0, 200, 3000);
      send_command(OP_ADJUST, 350, '0, 300, TIME_MIN);
      send_command(OP_ADJUST, 450, '0, 400, TIME_MAX);
      send_command(OP_ADJUST, 60, '0, 50, '0);
      send_command(OP_ADJUST, '0, '0, '0, 7);
      send_command(OP_ADJUST, TIME_MAX, '0, TIME_MIN, TIME_MAX);
      for (int i = 0; i < HIST_DEPTH; i++)
         send_command(OP_ADJUST, TIME_MAX, '0, TIME_MAX - 20000 + TIME_WIDTH'(1000 * i),
                      TIME_WIDTH'(1500 * i));

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 46; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 46; end
            default: begin send_idle_pct = 20; rsp_stall_pct = 20; end
         endcase
         repeat (RANDOM_PER_PHASE)
            random_command();
      end
      req_valid <= 1'b0;
      rsp_stall_pct = 0;

      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d command transfers across four pacing phases;", command_count);
      $display("%0d results carried a rate taken from the sync history.", history_ratio_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
